// ===== sv/scrs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package scrs_pkg;

  // Item codes carried on the func field.
  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_RECAL = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_LOW   = 2'd0;
  localparam logic [1:0] REG_HIGH  = 2'd1;
  localparam logic [1:0] REG_DELAY = 2'd2;

  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;
  localparam int DELAY_W = 17;
  localparam int SCALE_W = 16;

  localparam logic [DELAY_W-1:0] DELAY_RST   = 17'd60000;
  localparam logic [SCALE_W-1:0] SCALE_MIN   = 16'h8000;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SETUP = 4'b0010,
    S_DIV   = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ===== sv/scrs_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module scrs_div import scrs_pkg::*; #(
  parameter int DEN_W = 11,
  parameter int Q_W   = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [DEN_W+Q_W-1:0]   numer,
  input  wire logic [DEN_W-1:0]       denom,
  output div_stat_t                   stat,
  output logic      [Q_W-1:0]         quotient
);

  localparam int CNT_W = $clog2(Q_W);

  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [Q_W-1:0]   quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  // The caller guarantees the quotient fits in Q_W bits, so the upper part of
  // the dividend is already below the divisor and only Q_W steps are needed.
  assign trial = {rem_r, quo_r[Q_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(Q_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= numer[DEN_W+Q_W-1:Q_W];
      quo_r <= numer[Q_W-1:0];
      den_r <= denom;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_r <= {quo_r[Q_W-2:0], fits};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

`default_nettype wire

// ===== sv/self_calibrating_range_scaler.sv =====
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_ready    in_func, in_sample
// out       output     out_valid/out_ready  out_scaled_value, out_raw_echo,
//                                           out_save_now, out_save_low, out_save_high
// cfg       input      psel/penable/pwrite  paddr, pwdata, prdata (pready tied high)
//
// A read passes from acceptance through the setup state, the 16-step
// restoring divider (one quotient bit per cycle), the capture of the quotient
// and the hand-off before its result is valid. Recalibrate, tick and reads with
// equal bounds skip the divider. The input is ready again in the cycle after
// the result is loaded; the output register lets the next item enter while a
// result still waits. Reset is synchronous, active low.
`timescale 1ns / 1ps
`default_nettype none

module self_calibrating_range_scaler import scrs_pkg::*; #(
  parameter int SAMPLE_BITS = 10
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,

  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [1:0]                in_func,
  input  wire logic [SAMPLE_BITS-1:0]    in_sample,

  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed [SCALE_W-1:0]      out_scaled_value,
  output logic [SAMPLE_BITS-1:0]         out_raw_echo,
  output logic                           out_save_now,
  output logic [SAMPLE_BITS:0]           out_save_low,
  output logic [SAMPLE_BITS:0]           out_save_high,

  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [ADDR_W-1:0]         paddr,
  input  wire logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]              prdata,
  output logic                           pready
);

  localparam int BOUND_BITS = SAMPLE_BITS + 1;
  localparam logic [BOUND_BITS-1:0] HIGH_RST = {1'b0, {SAMPLE_BITS{1'b1}}};

  state_t state_r;

  logic [BOUND_BITS-1:0]  init_low_r;
  logic [BOUND_BITS-1:0]  init_high_r;
  logic [DELAY_W-1:0]     delay_r;

  logic [BOUND_BITS-1:0]  low_bound_r;
  logic [BOUND_BITS-1:0]  high_bound_r;
  logic                   save_pending_r;
  logic [DELAY_W-1:0]     elapsed_r;
  logic [SCALE_W-1:0]     last_scaled_r;
  logic [SAMPLE_BITS-1:0] last_raw_r;

  logic [1:0]             func_r;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic                   save_now_r;
  logic [BOUND_BITS-1:0]  save_low_r;
  logic [BOUND_BITS-1:0]  save_high_r;

  logic                   out_valid_r;
  logic [SCALE_W-1:0]     out_scaled_r;
  logic [SAMPLE_BITS-1:0] out_raw_r;
  logic                   out_save_r;
  logic [BOUND_BITS-1:0]  out_low_r;
  logic [BOUND_BITS-1:0]  out_high_r;

  logic                   cfg_wr;
  logic [1:0]             cfg_idx;
  logic [BOUND_BITS-1:0]  sample_ext;
  logic                   save_fire;
  logic [BOUND_BITS-1:0]  lo_wide;
  logic [BOUND_BITS-1:0]  hi_wide;
  logic [BOUND_BITS-1:0]  span;
  logic [BOUND_BITS-1:0]  offs;
  logic [BOUND_BITS+SCALE_W-1:0] numer;
  logic                   is_read;
  logic                   div_start;
  logic                   out_free;
  div_stat_t              div_st;
  logic [SCALE_W-1:0]     quotient;

  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[ADDR_W-1:2];
  assign pready  = 1'b1;

  always_comb begin
    unique case (cfg_idx)
      REG_LOW:   prdata = DATA_W'(init_low_r);
      REG_HIGH:  prdata = DATA_W'(init_high_r);
      REG_DELAY: prdata = DATA_W'(delay_r);
      default:   prdata = '0;
    endcase
  end

  // Setup-cycle datapath: save check on the old bounds, then widening.
  assign sample_ext = {1'b0, sample_r};
  assign save_fire  = save_pending_r && (elapsed_r > delay_r);
  assign lo_wide    = (sample_ext < low_bound_r) ? sample_ext : low_bound_r;
  assign hi_wide    = (sample_ext > high_bound_r) ? sample_ext : high_bound_r;
  assign span       = hi_wide - lo_wide;
  assign offs       = sample_ext - lo_wide;
  // offs * 65535 written as a shift and a subtract.
  assign numer      = {offs, {SCALE_W{1'b0}}} - {{SCALE_W{1'b0}}, offs};
  assign is_read    = (func_r == FUNC_READ);
  assign div_start  = (state_r == S_SETUP) && is_read && (span != '0);
  assign out_free   = !out_valid_r || out_ready;

  scrs_div #(
    .DEN_W (BOUND_BITS),
    .Q_W   (SCALE_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .numer    (numer),
    .denom    (span),
    .stat     (div_st),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE:  if (in_valid) state_r <= S_SETUP;
        S_SETUP: state_r <= div_start ? S_DIV : S_DONE;
        S_DIV:   if (div_st.done) state_r <= S_DONE;
        S_DONE:  if (out_free) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_r   <= in_func;
      sample_r <= in_sample;
    end
    if (state_r == S_SETUP) begin
      save_now_r  <= is_read && save_fire;
      save_low_r  <= (is_read && save_fire) ? low_bound_r : '0;
      save_high_r <= (is_read && save_fire) ? high_bound_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_low_r     <= '0;
      init_high_r    <= HIGH_RST;
      delay_r        <= DELAY_RST;
      low_bound_r    <= '0;
      high_bound_r   <= HIGH_RST;
      save_pending_r <= 1'b0;
      elapsed_r      <= '0;
      last_scaled_r  <= '0;
      last_raw_r     <= '0;
    end else begin
      if (cfg_wr && cfg_idx == REG_DELAY) begin
        delay_r <= pwdata[DELAY_W-1:0];
      end
      if (cfg_wr && cfg_idx == REG_LOW) begin
        init_low_r  <= pwdata[BOUND_BITS-1:0];
        low_bound_r <= pwdata[BOUND_BITS-1:0];
      end else if (state_r == S_SETUP && is_read) begin
        low_bound_r <= lo_wide;
      end else if (state_r == S_SETUP && func_r == FUNC_RECAL) begin
        low_bound_r <= sample_ext;
      end
      if (cfg_wr && cfg_idx == REG_HIGH) begin
        init_high_r  <= pwdata[BOUND_BITS-1:0];
        high_bound_r <= pwdata[BOUND_BITS-1:0];
      end else if (state_r == S_SETUP && is_read) begin
        high_bound_r <= hi_wide;
      end else if (state_r == S_SETUP && func_r == FUNC_RECAL) begin
        high_bound_r <= sample_ext + 1'b1;
      end
      if (state_r == S_SETUP) begin
        unique case (func_r)
          FUNC_READ: begin
            if (save_fire) save_pending_r <= 1'b0;
            last_raw_r <= sample_r;
            if (span == '0) last_scaled_r <= SCALE_MIN;
          end
          FUNC_RECAL: begin
            save_pending_r <= 1'b1;
            elapsed_r      <= '0;
            last_raw_r     <= sample_r;
          end
          FUNC_TICK: begin
            if (elapsed_r != {DELAY_W{1'b1}}) elapsed_r <= elapsed_r + 1'b1;
          end
          default: begin
          end
        endcase
      end
      // The quotient lies in 0..65535; flipping the top bit subtracts 32768.
      if (state_r == S_DIV && div_st.done) begin
        last_scaled_r <= quotient ^ SCALE_MIN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_scaled_r <= last_scaled_r;
      out_raw_r    <= last_raw_r;
      out_save_r   <= save_now_r;
      out_low_r    <= save_low_r;
      out_high_r   <= save_high_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_scaled_value = out_scaled_r;
  assign out_raw_echo     = out_raw_r;
  assign out_save_now     = out_save_r;
  assign out_save_low     = out_low_r;
  assign out_save_high    = out_high_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in progress");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_DONE) |-> !div_st.busy)
    else $error("divider running outside the divide phase");

  a_save_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_save_now) |-> (out_save_low == '0 && out_save_high == '0))
    else $error("save bounds nonzero without a save request");

  a_div_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> state_r == S_DIV)
    else $error("divider finished outside the divide phase");
`endif

endmodule

`default_nettype wire
